// File: design/assert_macros.svh
// assertion macros shared by the radix digit converter modules
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define RDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be true out of reset
`define RDC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: design/rdc_pkg.sv
// types, constants and codes of the radix digit converter
// no dependencies
package rdc_pkg;

  localparam int DigitW      = 8;
  localparam int RadixW      = 9;
  localparam int AccW        = DigitW + RadixW;
  localparam int StepW       = $clog2(DigitW);
  localparam int CfgIdxW     = 1;

  localparam int MaxInDigits  = 8;
  localparam int MaxOutDigits = 64;

  localparam logic [RadixW-1:0] SrcRadixReset = RadixW'(10);
  localparam logic [RadixW-1:0] TgtRadixReset = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMin      = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax      = RadixW'(256);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RADIX = 2'd1,
    ST_DIGIT = 2'd2,
    ST_COUNT = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SOURCE_RADIX = 1'b0,
    CFG_TARGET_RADIX = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_WAIT,
    S_READ,
    S_FETCH,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [DigitW-1:0] in_digit;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic [DigitW-1:0] out_digit;
    logic              out_last;
    status_e           status;
  } out_item_t;

  typedef struct packed {
    logic              done;
    logic [DigitW-1:0] quot;
    logic [DigitW-1:0] rem;
  } div_res_t;

  function automatic logic radix_ok(input logic [RadixW-1:0] r);
    return (r >= RadixMin) && (r <= RadixMax);
  endfunction

endpackage

// File: design/rdc_stream_if.sv
// valid/ready stream channel carrying one item per handshake
// payload type given by parameter, no other dependencies
interface rdc_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/rdc_ram.sv
// generic single write port ram with registered read
// no dependencies
module rdc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/rdc_divunit.sv
// shared multiply-accumulate and shift-subtract divider, one quotient bit per cycle
// depends on rdc_pkg and assert_macros.svh
`include "assert_macros.svh"

module rdc_divunit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rdc_pkg::DigitW-1:0] rem_i,
  input  logic [rdc_pkg::DigitW-1:0] digit_i,
  input  logic [rdc_pkg::RadixW-1:0] src_i,
  input  logic [rdc_pkg::RadixW-1:0] tgt_i,
  output rdc_pkg::div_res_t          res_o
);

  localparam int DigitW = rdc_pkg::DigitW;
  localparam int RadixW = rdc_pkg::RadixW;
  localparam int AccW   = rdc_pkg::AccW;
  localparam int StepW  = rdc_pkg::StepW;
  localparam logic [StepW-1:0] StepLast = StepW'(DigitW - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [RadixW-1:0] r_q, r_d;
  logic [DigitW-1:0] lo_q, lo_d;

  logic [AccW-1:0]   acc;
  logic [RadixW:0]   trial;
  logic [RadixW:0]   tgt_ext;
  logic              ge;
  logic [RadixW:0]   diff;

  always_comb begin
    acc     = {{RadixW{1'b0}}, rem_i} * {{DigitW{1'b0}}, src_i}
            + {{RadixW{1'b0}}, digit_i};
    trial   = {r_q, lo_q[DigitW-1]};
    tgt_ext = {1'b0, tgt_i};
    ge      = trial >= tgt_ext;
    diff    = ge ? (trial - tgt_ext) : trial;

    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    r_d    = r_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      r_d    = acc[AccW-1:DigitW];
      lo_d   = acc[DigitW-1:0];
    end else if (busy_q) begin
      r_d    = diff[RadixW-1:0];
      lo_d   = {lo_q[DigitW-2:0], ge};
      step_d = step_q + StepW'(1);
      if (step_q == StepLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q  <= r_d;
    lo_q <= lo_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = lo_q;
  assign res_o.rem  = r_q[DigitW-1:0];

  `RDC_ASSERT(a_start_idle, start_i |-> !busy_q, "divider started while busy")
  `RDC_ASSERT(a_done_after_busy, done_q |-> $past(busy_q), "divider done without run")

endmodule

// File: design/radix_digit_converter_core.sv
// Radix digit converter: digits arrive most significant first, one per item, and the
// item with in_last set starts the conversion. The input is ready throughout loading. The
// conversion runs repeated long division through one shared multiply-accumulate and
// shift-subtract divider: each working digit takes a start step, 8 quotient bits and a
// result step, and one pass over the remaining quotient digits yields one result digit.
// Result digits are then read back from the result ram through the read, fetch and
// output states, one item at a time.
// The input is not ready from the last digit until the last result item is taken.
// Error results are one item with digit 0, last set and a nonzero status.
// depends on rdc_pkg, rdc_stream_if, rdc_ram, rdc_divunit and assert_macros.svh
`include "assert_macros.svh"

module radix_digit_converter_core #(
  parameter int MAX_IN_DIGITS  = rdc_pkg::MaxInDigits,
  parameter int MAX_OUT_DIGITS = rdc_pkg::MaxOutDigits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rdc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rdc_pkg::RadixW-1:0]  cfg_data_i,
  rdc_stream_if.sink                  in_i,
  rdc_stream_if.source                out_o
);

  localparam int DigitW = rdc_pkg::DigitW;
  localparam int RadixW = rdc_pkg::RadixW;
  localparam int CntW   = $clog2(MAX_IN_DIGITS + 1);
  localparam int IdxW   = (MAX_IN_DIGITS > 1) ? $clog2(MAX_IN_DIGITS) : 1;
  localparam int NW     = $clog2(MAX_OUT_DIGITS + 1);
  localparam int AddrW  = $clog2(MAX_OUT_DIGITS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_IN_DIGITS);
  localparam logic [NW-1:0]   NMax   = NW'(MAX_OUT_DIGITS);

  rdc_pkg::state_e   state_q, state_d;
  logic [RadixW-1:0] src_q, tgt_q;
  logic [DigitW-1:0] store_q [MAX_IN_DIGITS];
  logic [CntW-1:0]   count_q, count_d;
  rdc_pkg::status_e  err_q, err_d;
  logic [CntW-1:0]   i_q, i_d;
  logic [CntW-1:0]   len_q, len_d;
  logic [CntW-1:0]   qlen_q, qlen_d;
  logic [DigitW-1:0] rem_q, rem_d;
  logic [NW-1:0]     n_q, n_d;
  logic [AddrW-1:0]  ptr_q, ptr_d;
  rdc_pkg::out_item_t out_q, out_d;

  logic              in_fire, out_fire;
  rdc_pkg::status_e  err_new, code_fin;
  logic [CntW-1:0]   count_new;
  logic              st_we;
  logic [IdxW-1:0]   st_waddr;
  logic [DigitW-1:0] st_wdata;
  logic              div_start;
  rdc_pkg::div_res_t div_res;
  logic              q_keep;
  logic [CntW-1:0]   qlen_new;
  logic [CntW-1:0]   i_next;
  logic              pass_end;
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [DigitW-1:0] ram_rdata;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= rdc_pkg::SrcRadixReset;
      tgt_q <= rdc_pkg::TgtRadixReset;
    end else if (cfg_we_i) begin
      unique case (rdc_pkg::cfg_reg_e'(cfg_idx_i))
        rdc_pkg::CFG_SOURCE_RADIX: src_q <= cfg_data_i;
        rdc_pkg::CFG_TARGET_RADIX: tgt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // digit checks and division bookkeeping
  always_comb begin
    err_new   = err_q;
    count_new = count_q;
    if ({1'b0, in_i.data.in_digit} >= src_q) begin
      err_new = rdc_pkg::ST_DIGIT;
    end
    if (count_q < CntMax) begin
      count_new = count_q + CntOne;
    end else if (err_new == rdc_pkg::ST_OK) begin
      err_new = rdc_pkg::ST_COUNT;
    end
    code_fin = err_new;
    if (!rdc_pkg::radix_ok(src_q) || !rdc_pkg::radix_ok(tgt_q)) begin
      code_fin = rdc_pkg::ST_RADIX;
    end

    q_keep   = (qlen_q != '0) || (div_res.quot != '0);
    qlen_new = q_keep ? (qlen_q + CntOne) : qlen_q;
    i_next   = i_q + CntOne;
    pass_end = !(i_next < len_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rdc_pkg::S_LOAD: begin
        if (in_fire && in_i.data.in_last) begin
          state_d = (code_fin == rdc_pkg::ST_OK) ? rdc_pkg::S_START : rdc_pkg::S_OUT;
        end
      end
      rdc_pkg::S_START: state_d = rdc_pkg::S_WAIT;
      rdc_pkg::S_WAIT: begin
        if (div_res.done) begin
          if (!pass_end) begin
            state_d = rdc_pkg::S_START;
          end else if (n_q == NMax) begin
            state_d = rdc_pkg::S_OUT;
          end else if (qlen_new == '0) begin
            state_d = rdc_pkg::S_READ;
          end else begin
            state_d = rdc_pkg::S_START;
          end
        end
      end
      rdc_pkg::S_READ:  state_d = rdc_pkg::S_FETCH;
      rdc_pkg::S_FETCH: state_d = rdc_pkg::S_OUT;
      rdc_pkg::S_OUT: begin
        if (out_fire) begin
          state_d = out_q.out_last ? rdc_pkg::S_LOAD : rdc_pkg::S_READ;
        end
      end
      default: state_d = rdc_pkg::S_LOAD;
    endcase
  end

  // datapath control
  always_comb begin
    count_d   = count_q;
    err_d     = err_q;
    i_d       = i_q;
    len_d     = len_q;
    qlen_d    = qlen_q;
    rem_d     = rem_q;
    n_d       = n_q;
    ptr_d     = ptr_q;
    out_d     = out_q;
    st_we     = 1'b0;
    st_waddr  = count_q[IdxW-1:0];
    st_wdata  = in_i.data.in_digit;
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = ptr_q;
    unique case (state_q)
      rdc_pkg::S_LOAD: begin
        if (in_fire) begin
          st_we = count_q < CntMax;
          if (in_i.data.in_last) begin
            count_d = '0;
            err_d   = rdc_pkg::ST_OK;
            len_d   = count_new;
            i_d     = '0;
            qlen_d  = '0;
            rem_d   = '0;
            n_d     = '0;
            out_d   = '{out_digit: '0, out_last: 1'b1, status: code_fin};
          end else begin
            count_d = count_new;
            err_d   = err_new;
          end
        end
      end
      rdc_pkg::S_START: div_start = 1'b1;
      rdc_pkg::S_WAIT: begin
        if (div_res.done) begin
          st_we    = q_keep;
          st_waddr = qlen_q[IdxW-1:0];
          st_wdata = div_res.quot;
          rem_d    = div_res.rem;
          qlen_d   = qlen_new;
          i_d      = i_next;
          if (pass_end) begin
            if (n_q == NMax) begin
              out_d = '{out_digit: '0, out_last: 1'b1, status: rdc_pkg::ST_COUNT};
            end else begin
              ram_we = 1'b1;
              n_d    = n_q + NW'(1);
              ptr_d  = n_q[AddrW-1:0];
              len_d  = qlen_new;
              i_d    = '0;
              qlen_d = '0;
              rem_d  = '0;
            end
          end
        end
      end
      rdc_pkg::S_READ: ram_re = 1'b1;
      rdc_pkg::S_FETCH: begin
        out_d = '{out_digit: ram_rdata, out_last: (ptr_q == '0), status: rdc_pkg::ST_OK};
      end
      rdc_pkg::S_OUT: begin
        if (out_fire && !out_q.out_last) begin
          ptr_d = ptr_q - AddrW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdc_pkg::S_LOAD;
      count_q <= '0;
      err_q   <= rdc_pkg::ST_OK;
      i_q     <= '0;
      len_q   <= '0;
      qlen_q  <= '0;
      n_q     <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      err_q   <= err_d;
      i_q     <= i_d;
      len_q   <= len_d;
      qlen_q  <= qlen_d;
      n_q     <= n_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    out_q <= out_d;
    if (st_we) begin
      store_q[st_waddr] <= st_wdata;
    end
  end

  rdc_divunit u_divunit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (rem_q),
    .digit_i (store_q[i_q[IdxW-1:0]]),
    .src_i   (src_q),
    .tgt_i   (tgt_q),
    .res_o   (div_res)
  );

  rdc_ram #(
    .Width (DigitW),
    .Depth (MAX_OUT_DIGITS)
  ) u_result_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (n_q[AddrW-1:0]),
    .wdata_i (div_res.rem),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready  = (state_q == rdc_pkg::S_LOAD);
  assign out_o.valid = (state_q == rdc_pkg::S_OUT);
  assign out_o.data  = out_q;

  `RDC_ASSERT_NEVER(a_one_side, in_i.ready && out_o.valid, "input ready while result pending")
  `RDC_ASSERT(a_count_bound, count_q <= CntMax, "digit count beyond store")
  `RDC_ASSERT(a_err_item, (out_o.valid && out_o.data.status != rdc_pkg::ST_OK) |-> (out_o.data.out_last && out_o.data.out_digit == '0), "error item not single")

endmodule
